// ===== hw/rtl/pbbd_pkg.sv =====
`default_nettype none

package pbbd_pkg;

    // fixed field widths
    localparam int TAG_W      = 16;
    localparam int PRIO_W     = 3;
    localparam int BANK_IDX_W = 2;

    // default sizing
    localparam int DEF_BUFFER_DEPTH = 8;
    localparam int DEF_BANK_COUNT   = 4;

    // event operation codes
    localparam logic OP_ARRIVAL = 1'b0;
    localparam logic OP_FREE    = 1'b1;

    // result kind codes
    localparam logic KIND_DISPATCH = 1'b0;
    localparam logic KIND_REJECT   = 1'b1;

    // controller to datapath commands
    typedef struct packed {
        logic accept;
        logic serve;
    } ctrl_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic out_free;
    } dp_status_t;

endpackage

`default_nettype wire

// ===== hw/rtl/pbbd_evt_if.sv =====
`default_nettype none

interface pbbd_evt_if import pbbd_pkg::*;;
    logic                  valid;
    logic                  ready;
    logic                  operation;
    logic [TAG_W-1:0]      request_tag;
    logic [PRIO_W-1:0]     request_priority;
    logic [BANK_IDX_W-1:0] bank_index;

    modport source (
        output valid, operation, request_tag, request_priority, bank_index,
        input  ready
    );

    modport sink (
        input  valid, operation, request_tag, request_priority, bank_index,
        output ready
    );
endinterface

`default_nettype wire

// ===== hw/rtl/pbbd_res_if.sv =====
`default_nettype none

interface pbbd_res_if import pbbd_pkg::*;;
    logic                  valid;
    logic                  ready;
    logic                  result_kind;
    logic [TAG_W-1:0]      result_tag;
    logic [PRIO_W-1:0]     result_priority;
    logic [BANK_IDX_W-1:0] target_bank;

    modport source (
        output valid, result_kind, result_tag, result_priority, target_bank,
        input  ready
    );

    modport sink (
        input  valid, result_kind, result_tag, result_priority, target_bank,
        output ready
    );
endinterface

`default_nettype wire

// ===== hw/rtl/pbbd_ctrl.sv =====
`default_nettype none

module pbbd_ctrl import pbbd_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  valid,
    output logic       ready,
    input  dp_status_t status,
    output ctrl_cmd_t  cmd
);

    localparam logic ST_IDLE  = 1'b0;
    localparam logic ST_SERVE = 1'b1;

    logic state_reg;
    logic state_next;

    // take an event only when idle
    assign ready      = (state_reg == ST_IDLE);
    assign cmd.accept = valid && ready;
    assign cmd.serve  = (state_reg == ST_SERVE) && status.out_free;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd.accept)
                begin
                    state_next = ST_SERVE;
                end
            end
            ST_SERVE:
            begin
                if (status.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/pbbd_datapath.sv =====
`default_nettype none

module pbbd_datapath import pbbd_pkg::*;
#(
    parameter int BUFFER_DEPTH = DEF_BUFFER_DEPTH,
    parameter int BANK_COUNT   = DEF_BANK_COUNT
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  ctrl_cmd_t                  cmd,
    output dp_status_t                 status,
    input  wire logic                  operation,
    input  wire logic [TAG_W-1:0]      request_tag,
    input  wire logic [PRIO_W-1:0]     request_priority,
    input  wire logic [BANK_IDX_W-1:0] bank_index,
    pbbd_res_if.source                 res
);

    localparam int SLOT_W = $clog2(BUFFER_DEPTH);
    localparam int LEAVES = 1 << SLOT_W;
    localparam int NODES  = 2 * LEAVES - 1;
    localparam int KEY_W  = 1 + PRIO_W + TAG_W;
    localparam int BANK_W = (BANK_COUNT > 1) ? $clog2(BANK_COUNT) : 1;
    localparam int BEXT_W = BANK_W + BANK_IDX_W;

    localparam logic [1:0] ACT_NONE   = 2'd0;
    localparam logic [1:0] ACT_REJECT = 2'd1;
    localparam logic [1:0] ACT_TRY    = 2'd2;

    // buffer and bank state
    logic [BUFFER_DEPTH-1:0] slot_valid_reg;
    logic [TAG_W-1:0]        slot_tag_reg  [BUFFER_DEPTH];
    logic [PRIO_W-1:0]       slot_prio_reg [BUFFER_DEPTH];
    logic [BANK_COUNT-1:0]   bank_free_reg;
    logic [BANK_W-1:0]       search_start_reg;
    logic [SLOT_W-1:0]       newest_reg;

    // pending work between accept and serve
    logic [1:0]              act_reg;
    logic [TAG_W-1:0]        rej_tag_reg;
    logic [PRIO_W-1:0]       rej_prio_reg;

    // output register
    logic                    out_valid_reg;
    logic                    out_kind_reg;
    logic [TAG_W-1:0]        out_tag_reg;
    logic [PRIO_W-1:0]       out_prio_reg;
    logic [BANK_IDX_W-1:0]   out_bank_reg;

    logic                    empty_found;
    logic [SLOT_W-1:0]       empty_idx;
    logic [SLOT_W-1:0]       wr_idx;
    logic [BEXT_W-1:0]       bidx_ext;
    logic                    bidx_in_range;
    logic [BANK_W-1:0]       bidx;

    logic [KEY_W-1:0]        key_node [NODES];
    logic [SLOT_W-1:0]       idx_node [NODES];
    logic                    best_found;
    logic [SLOT_W-1:0]       best_idx;

    logic                    bank_found;
    logic                    bank_hi_found;
    logic [BANK_W-1:0]       bank_hi_idx;
    logic [BANK_W-1:0]       bank_any_idx;
    logic [BANK_W-1:0]       bank_sel;
    logic [BEXT_W-1:0]       bank_sel_ext;

    logic                    do_reject;
    logic                    do_dispatch;

    assign status.out_free = !out_valid_reg || res.ready;

    // lowest empty slot
    always_comb
    begin
        empty_found = 1'b0;
        empty_idx   = '0;
        for (int i = BUFFER_DEPTH - 1; i >= 0; i--)
        begin
            if (!slot_valid_reg[i])
            begin
                empty_found = 1'b1;
                empty_idx   = SLOT_W'(i);
            end
        end
    end

    // full buffer overwrites the newest entry
    assign wr_idx = empty_found ? empty_idx : newest_reg;

    // freed bank index check
    assign bidx_ext      = {{BANK_W{1'b0}}, bank_index};
    assign bidx_in_range = bidx_ext < BEXT_W'(BANK_COUNT);
    assign bidx          = bidx_ext[BANK_W-1:0];

    // best request: valid first, then higher priority, then smaller tag, then lower slot
    for (genvar i = 0; i < LEAVES; i++)
    begin : g_leaf
        if (i < BUFFER_DEPTH)
        begin : g_used
            assign key_node[LEAVES-1+i] = {slot_valid_reg[i], slot_prio_reg[i], ~slot_tag_reg[i]};
        end
        else
        begin : g_pad
            assign key_node[LEAVES-1+i] = '0;
        end
        assign idx_node[LEAVES-1+i] = SLOT_W'(i);
    end

    for (genvar n = 0; n < LEAVES - 1; n++)
    begin : g_node
        logic pick_left;
        assign pick_left   = key_node[2*n+1] >= key_node[2*n+2];
        assign key_node[n] = pick_left ? key_node[2*n+1] : key_node[2*n+2];
        assign idx_node[n] = pick_left ? idx_node[2*n+1] : idx_node[2*n+2];
    end

    assign best_found = key_node[0][KEY_W-1];
    assign best_idx   = idx_node[0];

    // first free bank, circular from the search pointer
    always_comb
    begin
        bank_found    = 1'b0;
        bank_hi_found = 1'b0;
        bank_hi_idx   = '0;
        bank_any_idx  = '0;
        for (int b = BANK_COUNT - 1; b >= 0; b--)
        begin
            if (bank_free_reg[b])
            begin
                bank_found   = 1'b1;
                bank_any_idx = BANK_W'(b);
                if (BANK_W'(b) >= search_start_reg)
                begin
                    bank_hi_found = 1'b1;
                    bank_hi_idx   = BANK_W'(b);
                end
            end
        end
    end

    assign bank_sel     = bank_hi_found ? bank_hi_idx : bank_any_idx;
    assign bank_sel_ext = {{BANK_IDX_W{1'b0}}, bank_sel};

    // what the serve step emits
    assign do_reject   = cmd.serve && (act_reg == ACT_REJECT);
    assign do_dispatch = cmd.serve && (act_reg == ACT_TRY) && best_found && bank_found;

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_valid_reg   <= '0;
            bank_free_reg    <= '1;
            search_start_reg <= BANK_W'(BANK_COUNT - 1);
            newest_reg       <= '0;
            act_reg          <= ACT_NONE;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cmd.accept)
            begin
                if (operation == OP_ARRIVAL)
                begin
                    slot_valid_reg[wr_idx] <= 1'b1;
                    if (empty_found)
                    begin
                        newest_reg <= empty_idx;
                        act_reg    <= ACT_TRY;
                    end
                    else
                    begin
                        act_reg <= ACT_REJECT;
                    end
                end
                else if (bidx_in_range)
                begin
                    bank_free_reg[bidx] <= 1'b1;
                    search_start_reg    <= bidx;
                    act_reg             <= ACT_TRY;
                end
                else
                begin
                    act_reg <= ACT_NONE;
                end
            end
            else if (cmd.serve)
            begin
                act_reg <= ACT_NONE;
            end

            if (do_dispatch)
            begin
                slot_valid_reg[best_idx] <= 1'b0;
                bank_free_reg[bank_sel]  <= 1'b0;
            end

            // output register handshake
            if (do_reject || do_dispatch)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (res.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload storage
    always_ff @(posedge clk)
    begin
        if (cmd.accept && (operation == OP_ARRIVAL))
        begin
            slot_tag_reg[wr_idx]  <= request_tag;
            slot_prio_reg[wr_idx] <= request_priority;
            rej_tag_reg           <= slot_tag_reg[newest_reg];
            rej_prio_reg          <= slot_prio_reg[newest_reg];
        end

        if (do_reject)
        begin
            out_kind_reg <= KIND_REJECT;
            out_tag_reg  <= rej_tag_reg;
            out_prio_reg <= rej_prio_reg;
            out_bank_reg <= '0;
        end
        else if (do_dispatch)
        begin
            out_kind_reg <= KIND_DISPATCH;
            out_tag_reg  <= slot_tag_reg[best_idx];
            out_prio_reg <= slot_prio_reg[best_idx];
            out_bank_reg <= bank_sel_ext[BANK_IDX_W-1:0];
        end
    end

    assign res.valid           = out_valid_reg;
    assign res.result_kind     = out_kind_reg;
    assign res.result_tag      = out_tag_reg;
    assign res.result_priority = out_prio_reg;
    assign res.target_bank     = out_bank_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/priority_buffer_bank_dispatcher_unit.sv =====
// Priority request buffer with circular bank dispatch. Each event on evt is
// either a request arrival (tag, priority) or a bank-freed notice. Arrivals go
// into the lowest empty slot; when the buffer is full the most recently
// inserted request is rejected on res and the new one takes its slot. Whenever
// a bank is free and requests wait, the highest-priority request (smallest tag
// among equals, lowest slot among full ties) is dispatched to the first free
// bank found circularly upward from the bank freed last. Each event yields zero
// or one result. An event is handled in two steps: the accept step updates the
// buffer and bank flags, then the serve step runs the slot compare tree and the
// circular bank search and loads the output register; the serve step waits
// while the output register still holds a result not yet taken. There is no
// clearing pass after reset.

`default_nettype none

module priority_buffer_bank_dispatcher_unit import pbbd_pkg::*;
#(
    parameter int BUFFER_DEPTH = DEF_BUFFER_DEPTH,
    parameter int BANK_COUNT   = DEF_BANK_COUNT
)
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    pbbd_evt_if.sink   evt,
    pbbd_res_if.source res
);

    ctrl_cmd_t  cmd;
    dp_status_t status;
    logic       ready;

    assign evt.ready = ready;

    // sequencer
    pbbd_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .valid  (evt.valid),
        .ready  (ready),
        .status (status),
        .cmd    (cmd)
    );

    // buffer, bank flags and selection logic
    pbbd_datapath #(
        .BUFFER_DEPTH (BUFFER_DEPTH),
        .BANK_COUNT   (BANK_COUNT)
    ) u_datapath (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .status           (status),
        .operation        (evt.operation),
        .request_tag      (evt.request_tag),
        .request_priority (evt.request_priority),
        .bank_index       (evt.bank_index),
        .res              (res)
    );

    // after an accepted event the block is busy and takes no new event
    a_accept_then_busy: assert property (
        @(posedge clk) disable iff (!rst_n)
        cmd.accept |=> !evt.ready
    ) else $error("event accepted while previous event still in service");

    // results are only loaded when the output register can take them
    a_serve_needs_room: assert property (
        @(posedge clk) disable iff (!rst_n)
        cmd.serve |-> status.out_free
    ) else $error("serve issued with output register occupied");

    // a new result only appears right after a serve cycle
    a_result_from_serve: assert property (
        @(posedge clk) disable iff (!rst_n)
        $rose(res.valid) |-> $past(cmd.serve)
    ) else $error("result appeared without a serve cycle");

    // accept and serve never coincide
    a_cmd_exclusive: assert property (
        @(posedge clk) disable iff (!rst_n)
        !(cmd.accept && cmd.serve)
    ) else $error("accept and serve in the same cycle");

endmodule

`default_nettype wire

// ===== test/priority_buffer_bank_dispatcher_unit_tb.sv =====
`timescale 1ns / 100ps

module priority_buffer_bank_dispatcher_unit_tb;
    import pbbd_pkg::*;

    localparam int DEPTH          = DEF_BUFFER_DEPTH;
    localparam int BANKS          = DEF_BANK_COUNT;
    localparam int DIRECTED_COUNT = 29;
    localparam int RANDOM_COUNT   = 680;
    localparam int SEGMENT_LEN    = 50;
    localparam int HOLD_AT_RESULT = 120;
    localparam int LONG_HOLD      = 400;
    localparam int PAUSE_AT_ITEM  = 350;
    localparam int SETTLE_CYCLES  = 8;
    localparam int DRAIN_LIMIT    = 20000;
    localparam int CYCLE_LIMIT    = 200000;

    // one dispatch or reject as it leaves the block
    typedef struct packed {
        logic                  kind;
        logic [TAG_W-1:0]      tag;
        logic [PRIO_W-1:0]     prio;
        logic [BANK_IDX_W-1:0] bank;
    } outcome_t;

    // one row of the directed table; fixed rows carry a hand-typed result
    typedef struct packed {
        logic                  op;
        logic [TAG_W-1:0]      tag;
        logic [PRIO_W-1:0]     prio;
        logic [BANK_IDX_W-1:0] bank;
        logic                  fixed;
        outcome_t              want;
    } stim_row_t;

    logic clk = 1'b0;
    logic rst_n;
    int   cycle_count = 0;
    int   fail_count = 0;
    int   taken_count = 0;
    bit   send_idle_on = 1'b1;
    bit   take_idle_on = 1'b1;

    // shadow copy of the request buffer and bank flags
    logic              slot_used  [DEPTH];
    logic [TAG_W-1:0]  slot_tags  [DEPTH];
    logic [PRIO_W-1:0] slot_prios [DEPTH];
    logic              bank_idle  [BANKS];
    int                search_from;
    int                newest;

    outcome_t pending_outcomes [$];

    // fill all banks, fill the buffer with ties, overflow it, drain, wrap the bank search
    stim_row_t directed_rows [DIRECTED_COUNT] = '{
        '{OP_ARRIVAL, 16'h0000, 3'd0, 2'd0, 1'b1, '{KIND_DISPATCH, 16'h0000, 3'd0, 2'd3}},
        '{OP_ARRIVAL, 16'hFFFF, 3'd7, 2'd0, 1'b1, '{KIND_DISPATCH, 16'hFFFF, 3'd7, 2'd0}},
        '{OP_ARRIVAL, 16'h1234, 3'd5, 2'd0, 1'b1, '{KIND_DISPATCH, 16'h1234, 3'd5, 2'd1}},
        '{OP_ARRIVAL, 16'h0042, 3'd2, 2'd0, 1'b1, '{KIND_DISPATCH, 16'h0042, 3'd2, 2'd2}},
        '{OP_ARRIVAL, 16'h0064, 3'd4, 2'd0, 1'b0, '0},
        '{OP_ARRIVAL, 16'h0032, 3'd4, 2'd0, 1'b0, '0},
        '{OP_ARRIVAL, 16'h0032, 3'd4, 2'd0, 1'b0, '0},
        '{OP_ARRIVAL, 16'hFFFF, 3'd7, 2'd0, 1'b0, '0},
        '{OP_ARRIVAL, 16'h0000, 3'd0, 2'd0, 1'b0, '0},
        '{OP_ARRIVAL, 16'h0007, 3'd6, 2'd0, 1'b0, '0},
        '{OP_ARRIVAL, 16'h012C, 3'd1, 2'd0, 1'b0, '0},
        '{OP_ARRIVAL, 16'h8000, 3'd3, 2'd0, 1'b0, '0},
        '{OP_ARRIVAL, 16'h0009, 3'd7, 2'd0, 1'b1, '{KIND_REJECT, 16'h8000, 3'd3, 2'd0}},
        '{OP_ARRIVAL, 16'h000B, 3'd2, 2'd0, 1'b1, '{KIND_REJECT, 16'h0009, 3'd7, 2'd0}},
        '{OP_FREE,    16'h0000, 3'd0, 2'd2, 1'b0, '0},
        '{OP_FREE,    16'h0000, 3'd0, 2'd1, 1'b0, '0},
        '{OP_FREE,    16'h0000, 3'd0, 2'd3, 1'b0, '0},
        '{OP_FREE,    16'h0000, 3'd0, 2'd0, 1'b0, '0},
        '{OP_ARRIVAL, 16'h0001, 3'd4, 2'd0, 1'b0, '0},
        '{OP_FREE,    16'h0000, 3'd0, 2'd3, 1'b0, '0},
        '{OP_FREE,    16'h0000, 3'd0, 2'd2, 1'b0, '0},
        '{OP_FREE,    16'h0000, 3'd0, 2'd1, 1'b0, '0},
        '{OP_FREE,    16'h0000, 3'd0, 2'd0, 1'b0, '0},
        '{OP_FREE,    16'h0000, 3'd0, 2'd3, 1'b0, '0},
        '{OP_FREE,    16'h0000, 3'd0, 2'd2, 1'b0, '0},
        '{OP_FREE,    16'h0000, 3'd0, 2'd2, 1'b0, '0},
        '{OP_FREE,    16'h0000, 3'd0, 2'd3, 1'b0, '0},
        '{OP_ARRIVAL, 16'h00AA, 3'd3, 2'd0, 1'b0, '0},
        '{OP_ARRIVAL, 16'h00BB, 3'd3, 2'd0, 1'b0, '0}
    };

    pbbd_evt_if evt_bus ();
    pbbd_res_if res_bus ();

    priority_buffer_bank_dispatcher_unit DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .evt   (evt_bus),
        .res   (res_bus)
    );

    // clock
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // reset, asserted once
    initial
    begin
        rst_n = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("%0t: run limit reached", $time);
            $display("Some tests failed");
            $finish;
        end
    end

    // buffer and bank state after reset
    function automatic void clear_schedule();
        for (int s = 0; s < DEPTH; s++)
        begin
            slot_used[s]  = 1'b0;
            slot_tags[s]  = '0;
            slot_prios[s] = '0;
        end
        for (int b = 0; b < BANKS; b++)
            bank_idle[b] = 1'b1;
        search_from = BANKS - 1;
        newest      = 0;
    endfunction

    // append one expected result behind the ones already waiting
    function automatic void enqueue_outcome(input outcome_t o);
        pending_outcomes.insert(pending_outcomes.size(), o);
    endfunction

    // best waiting request to the first idle bank from the search pointer
    function automatic bit serve_best(output outcome_t o);
        int best;
        int bank;
        int b;
        o    = '0;
        best = -1;
        bank = -1;
        for (int s = 0; s < DEPTH; s++)
        begin
            if (slot_used[s] && (best < 0 || slot_prios[s] > slot_prios[best] ||
                (slot_prios[s] == slot_prios[best] && slot_tags[s] < slot_tags[best])))
                best = s;
        end
        if (best < 0)
            return 1'b0;
        for (int k = 0; k < BANKS; k++)
        begin
            b = (search_from + k) % BANKS;
            if (bank_idle[b] && bank < 0)
                bank = b;
        end
        if (bank < 0)
            return 1'b0;
        bank_idle[bank] = 1'b0;
        slot_used[best] = 1'b0;
        o = '{KIND_DISPATCH, slot_tags[best], slot_prios[best], BANK_IDX_W'(bank)};
        return 1'b1;
    endfunction

    // apply one accepted request to the shadow state, return its result if any
    function automatic bit schedule_request(input logic op, input logic [TAG_W-1:0] tag,
                                            input logic [PRIO_W-1:0] prio,
                                            input logic [BANK_IDX_W-1:0] bank,
                                            output outcome_t o);
        int empty;
        int n;
        o     = '0;
        empty = -1;
        if (op == OP_ARRIVAL)
        begin
            for (int s = 0; s < DEPTH; s++)
            begin
                if (!slot_used[s] && empty < 0)
                    empty = s;
            end
            // full buffer: newest entry is bumped, pointer stays
            if (empty < 0)
            begin
                n = newest % DEPTH;
                o = '{KIND_REJECT, slot_tags[n], slot_prios[n], 2'd0};
                slot_tags[n]  = tag;
                slot_prios[n] = prio;
                slot_used[n]  = 1'b1;
                return 1'b1;
            end
            slot_tags[empty]  = tag;
            slot_prios[empty] = prio;
            slot_used[empty]  = 1'b1;
            newest = empty;
            return serve_best(o);
        end
        if (int'(bank) >= BANKS)
            return 1'b0;
        bank_idle[bank] = 1'b1;
        search_from = int'(bank);
        return serve_best(o);
    endfunction

    // offer one request to the block and record what it should produce
    task automatic offer_request(input logic op, input logic [TAG_W-1:0] tag,
                                 input logic [PRIO_W-1:0] prio,
                                 input logic [BANK_IDX_W-1:0] bank,
                                 input logic fixed, input outcome_t want);
        int       gap;
        bit       has_result;
        outcome_t predicted;
        gap = send_idle_on ? $urandom_range(0, 19) : 0;
        if (gap > 0)
        begin
            evt_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        evt_bus.valid            <= 1'b1;
        evt_bus.operation        <= op;
        evt_bus.request_tag      <= tag;
        evt_bus.request_priority <= prio;
        evt_bus.bank_index       <= bank;
        do
            @(posedge clk);
        while (!(evt_bus.valid && evt_bus.ready));
        has_result = schedule_request(op, tag, prio, bank, predicted);
        if (fixed)
            enqueue_outcome(want);
        else if (has_result)
            enqueue_outcome(predicted);
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected 0x%0h actual 0x%0h", $time, name, want, got);
            fail_count++;
        end
    endtask

    // result side: random stalls, one long hold-off, compare against oldest expectation
    initial
    begin
        int       gap;
        bit       held;
        outcome_t got;
        outcome_t want;
        held = 1'b0;
        res_bus.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (!held && taken_count == HOLD_AT_RESULT)
            begin
                held = 1'b1;
                gap  = LONG_HOLD;
            end
            else
                gap = take_idle_on ? $urandom_range(0, 19) : 0;
            if (gap > 0)
            begin
                res_bus.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            res_bus.ready <= 1'b1;
            do
                @(posedge clk);
            while (!(res_bus.valid && res_bus.ready));
            got = '{res_bus.result_kind, res_bus.result_tag, res_bus.result_priority,
                    res_bus.target_bank};
            taken_count++;
            if (pending_outcomes.size() == 0)
            begin
                $display("%0t: unexpected result, expected none actual kind %0d tag 0x%0h",
                         $time, got.kind, got.tag);
                fail_count++;
            end
            else
            begin
                want = pending_outcomes.pop_front();
                check_field("result_kind", want.kind, got.kind);
                check_field("result_tag", want.tag, got.tag);
                check_field("result_priority", want.prio, got.prio);
                check_field("target_bank", want.bank, got.bank);
            end
        end
    end

    // request side: directed table, then random segments, then drain
    initial
    begin
        int               arrive_pct;
        int               drain_wait;
        logic             op;
        logic [TAG_W-1:0] tag;
        evt_bus.valid            <= 1'b0;
        evt_bus.operation        <= OP_ARRIVAL;
        evt_bus.request_tag      <= '0;
        evt_bus.request_priority <= '0;
        evt_bus.bank_index       <= '0;
        arrive_pct = 50;
        clear_schedule();
        wait (rst_n === 1'b1);
        @(posedge clk);

        for (int i = 0; i < DIRECTED_COUNT; i++)
            offer_request(directed_rows[i].op, directed_rows[i].tag, directed_rows[i].prio,
                          directed_rows[i].bank, directed_rows[i].fixed,
                          directed_rows[i].want);

        for (int i = 0; i < RANDOM_COUNT; i++)
        begin
            // new mix of arrivals, frees and idling every segment
            if (i % SEGMENT_LEN == 0)
            begin
                case ($urandom_range(0, 3))
                    0: arrive_pct = 25;
                    1: arrive_pct = 50;
                    2: arrive_pct = 75;
                    default: arrive_pct = 90;
                endcase
                send_idle_on = ($urandom_range(0, 3) != 0);
                take_idle_on = ($urandom_range(0, 3) != 0);
            end
            // let the block drain completely once
            if (i == PAUSE_AT_ITEM)
            begin
                evt_bus.valid <= 1'b0;
                while (pending_outcomes.size() != 0)
                    @(posedge clk);
                repeat (SETTLE_CYCLES) @(posedge clk);
            end
            op  = ($urandom_range(0, 99) < arrive_pct) ? OP_ARRIVAL : OP_FREE;
            // mostly small tags so equal priorities often meet close tags
            tag = ($urandom_range(0, 3) == 0) ? TAG_W'($urandom_range(0, 65535))
                                              : TAG_W'($urandom_range(0, 31));
            offer_request(op, tag, PRIO_W'($urandom_range(0, 7)),
                          BANK_IDX_W'($urandom_range(0, BANKS - 1)), 1'b0, '0);
        end
        evt_bus.valid <= 1'b0;

        drain_wait = 0;
        while (pending_outcomes.size() != 0 && drain_wait < DRAIN_LIMIT)
        begin
            @(posedge clk);
            drain_wait++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (pending_outcomes.size() != 0)
        begin
            $display("%0t: %0d results still expected, actual none", $time,
                     pending_outcomes.size());
            fail_count++;
        end
        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
